[rtl/assert_macros.svh]
// Assertion helpers for the RTL files; the sequencer top includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked at every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

[rtl/i2cseq_pkg.sv]
package i2cseq_pkg;

  localparam int BUF_DEPTH = 256;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_EVENT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_PENDING = 2'd0,
    ST_SUCCESS = 2'd1,
    ST_FAILED  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE          = 4'd0,
    PH_SEND_ADDR     = 4'd1,
    PH_ADDR_ACK      = 4'd2,
    PH_DATA_ACK      = 4'd3,
    PH_RESTART_STOP  = 4'd4,
    PH_RESTART_START = 4'd5,
    PH_READ_ADDR     = 4'd6,
    PH_FIRST_RX      = 4'd7,
    PH_RX_BYTE       = 4'd8,
    PH_RX_ENABLE     = 4'd9,
    PH_SUCCESS_WAIT  = 4'd10,
    PH_FAIL_WAIT     = 4'd11
  } phase_t;

  typedef struct packed {
    logic       accepted;
    logic       issue_start;
    logic       issue_stop;
    logic       enable_receive;
    logic       send_ack;
    logic       load_transmit;
    logic       tx_from_ram;
    logic [7:0] transmit_byte;
    logic       rx_valid;
    logic [7:0] rx_index;
    logic [7:0] rx_value;
    status_t    status;
  } result_t;

endpackage

[rtl/i2cseq_ram.sv]
module i2cseq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/i2c_master_transaction_sequencer_top.sv]
// Channel  Direction  Payload
// in_      slave      tuser: mode; tdata: request fields (56 bits)
// out_     master     tdata: result fields (40 bits)
//
// Every request yields one result, valid the cycle after acceptance; one request per cycle
// while the result is not stalled. The data buffer is a one-port-read, one-port-write RAM;
// a write-data read is issued at acceptance; its data is muxed into the registered result.
// A stalled result holds the input: in_tready = !out_tvalid || out_tready.
// Reset (rst_n low, synchronous) clears the phase and status; the buffer is not cleared.
`include "assert_macros.svh"

module i2c_master_transaction_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // buf_index[7:0], buf_byte[15:8], slave_addr[23:16], reg_addr[31:24],
  // byte_count[39:32], nack[40], collision[41], rx_data[49:42], zero[55:50]
  input  logic [55:0] in_tdata,
  // mode[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // accepted[0], issue_start[1], issue_stop[2], enable_receive[3], send_ack[4],
  // load_transmit[5], transmit_byte[13:6], rx_valid[14], rx_index[22:15],
  // rx_value[30:23], status[32:31], zero[39:33]
  output logic [39:0] out_tdata
);

  localparam int AW = i2cseq_pkg::BUF_AW;

  // Input fields.
  logic [7:0] buf_index, buf_byte, slave_addr, reg_addr, byte_count, rx_data;
  logic       nack, collision;
  i2cseq_pkg::mode_t mode;

  assign buf_index  = in_tdata[7:0];
  assign buf_byte   = in_tdata[15:8];
  assign slave_addr = in_tdata[23:16];
  assign reg_addr   = in_tdata[31:24];
  assign byte_count = in_tdata[39:32];
  assign nack       = in_tdata[40];
  assign collision  = in_tdata[41];
  assign rx_data    = in_tdata[49:42];
  assign mode       = i2cseq_pkg::mode_t'(in_tuser);

  // Transfer state.
  i2cseq_pkg::phase_t  phase_r, phase_nxt;
  i2cseq_pkg::status_t status_r, status_nxt;
  logic       dir_rd_r, dir_rd_nxt;
  logic [7:0] tgt_r, tgt_nxt;
  logic [7:0] regad_r, regad_nxt;
  logic [7:0] total_r, total_nxt;
  logic [7:0] pos_r, pos_nxt;

  // Result stage.
  logic                  out_valid_r;
  i2cseq_pkg::result_t   res_r, res;

  // Buffer RAM controls.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic in_acc, is_event, is_start, can_start;
  logic [7:0] pos_inc;
  logic more_wr, more_rx, pos_in_range, idx_in_range;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign is_event  = (mode == i2cseq_pkg::MODE_EVENT) && (phase_r != i2cseq_pkg::PH_IDLE);
  assign is_start  = (mode == i2cseq_pkg::MODE_WRITE) || (mode == i2cseq_pkg::MODE_READ);
  assign can_start = (status_r != i2cseq_pkg::ST_PENDING);

  assign pos_inc      = pos_r + 8'd1;
  assign more_wr      = (pos_r < total_r);
  assign more_rx      = (pos_inc < total_r);
  assign pos_in_range = ({1'b0, pos_r} < 9'(i2cseq_pkg::BUF_DEPTH));
  assign idx_in_range = ({1'b0, buf_index} < 9'(i2cseq_pkg::BUF_DEPTH));

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (in_acc) begin
      if (is_start && can_start) begin
        phase_nxt = i2cseq_pkg::PH_SEND_ADDR;
      end else if (is_event) begin
        if (collision) begin
          phase_nxt = i2cseq_pkg::PH_FAIL_WAIT;
        end else begin
          unique case (phase_r)
            i2cseq_pkg::PH_SEND_ADDR: phase_nxt = i2cseq_pkg::PH_ADDR_ACK;
            i2cseq_pkg::PH_ADDR_ACK: begin
              if (nack) begin
                phase_nxt = i2cseq_pkg::PH_FAIL_WAIT;
              end else if (dir_rd_r) begin
                phase_nxt = i2cseq_pkg::PH_RESTART_STOP;
              end else begin
                phase_nxt = more_wr ? i2cseq_pkg::PH_DATA_ACK : i2cseq_pkg::PH_SUCCESS_WAIT;
              end
            end
            i2cseq_pkg::PH_DATA_ACK: begin
              if (nack) begin
                phase_nxt = i2cseq_pkg::PH_FAIL_WAIT;
              end else begin
                phase_nxt = more_wr ? i2cseq_pkg::PH_DATA_ACK : i2cseq_pkg::PH_SUCCESS_WAIT;
              end
            end
            i2cseq_pkg::PH_RESTART_STOP:  phase_nxt = i2cseq_pkg::PH_RESTART_START;
            i2cseq_pkg::PH_RESTART_START: phase_nxt = i2cseq_pkg::PH_READ_ADDR;
            i2cseq_pkg::PH_READ_ADDR:     phase_nxt = i2cseq_pkg::PH_FIRST_RX;
            i2cseq_pkg::PH_FIRST_RX: begin
              phase_nxt = nack ? i2cseq_pkg::PH_FAIL_WAIT : i2cseq_pkg::PH_RX_BYTE;
            end
            i2cseq_pkg::PH_RX_BYTE: begin
              phase_nxt = more_rx ? i2cseq_pkg::PH_RX_ENABLE : i2cseq_pkg::PH_SUCCESS_WAIT;
            end
            i2cseq_pkg::PH_RX_ENABLE: phase_nxt = i2cseq_pkg::PH_RX_BYTE;
            default:                  phase_nxt = i2cseq_pkg::PH_IDLE;
          endcase
        end
      end
    end
  end

  // Result fields, register updates and buffer accesses.
  always_comb begin
    res        = '0;
    status_nxt = status_r;
    dir_rd_nxt = dir_rd_r;
    tgt_nxt    = tgt_r;
    regad_nxt  = regad_r;
    total_nxt  = total_r;
    pos_nxt    = pos_r;
    ram_we     = 1'b0;
    ram_waddr  = buf_index[AW-1:0];
    ram_wdata  = buf_byte;
    ram_re     = 1'b0;
    ram_raddr  = pos_r[AW-1:0];

    if (in_acc) begin
      if (mode == i2cseq_pkg::MODE_LOAD) begin
        ram_we = idx_in_range;
      end else if (is_start) begin
        if (can_start) begin
          tgt_nxt         = slave_addr;
          regad_nxt       = reg_addr;
          total_nxt       = byte_count;
          pos_nxt         = 8'd0;
          dir_rd_nxt      = (mode == i2cseq_pkg::MODE_READ);
          status_nxt      = i2cseq_pkg::ST_PENDING;
          res.accepted    = 1'b1;
          res.issue_start = 1'b1;
        end
      end else if (is_event) begin
        if (collision) begin
          res.issue_stop = 1'b1;
        end else begin
          unique case (phase_r)
            i2cseq_pkg::PH_SEND_ADDR: begin
              res.load_transmit = 1'b1;
              res.transmit_byte = tgt_r;
            end
            i2cseq_pkg::PH_ADDR_ACK, i2cseq_pkg::PH_DATA_ACK: begin
              if (nack) begin
                res.issue_stop = 1'b1;
              end else if (dir_rd_r && phase_r == i2cseq_pkg::PH_ADDR_ACK) begin
                res.load_transmit = 1'b1;
                res.transmit_byte = regad_r;
              end else if (more_wr) begin
                // The data byte arrives from the buffer RAM next cycle.
                res.load_transmit = 1'b1;
                res.tx_from_ram   = pos_in_range;
                ram_re            = pos_in_range;
                pos_nxt           = pos_inc;
              end else begin
                res.issue_stop = 1'b1;
              end
            end
            i2cseq_pkg::PH_RESTART_STOP:  res.issue_stop = 1'b1;
            i2cseq_pkg::PH_RESTART_START: res.issue_start = 1'b1;
            i2cseq_pkg::PH_READ_ADDR: begin
              res.load_transmit = 1'b1;
              res.transmit_byte = tgt_r + 8'd1;
            end
            i2cseq_pkg::PH_FIRST_RX: begin
              if (nack) begin
                res.issue_stop = 1'b1;
              end else begin
                res.enable_receive = 1'b1;
              end
            end
            i2cseq_pkg::PH_RX_BYTE: begin
              ram_we       = pos_in_range;
              ram_waddr    = pos_r[AW-1:0];
              ram_wdata    = rx_data;
              res.rx_valid = 1'b1;
              res.rx_index = pos_r;
              res.rx_value = rx_data;
              pos_nxt      = pos_inc;
              if (more_rx) begin
                res.send_ack = 1'b1;
              end else begin
                res.issue_stop = 1'b1;
              end
            end
            i2cseq_pkg::PH_RX_ENABLE:    res.enable_receive = 1'b1;
            i2cseq_pkg::PH_SUCCESS_WAIT: status_nxt = i2cseq_pkg::ST_SUCCESS;
            i2cseq_pkg::PH_FAIL_WAIT:    status_nxt = i2cseq_pkg::ST_FAILED;
            default: ;
          endcase
        end
      end
    end
    res.status = status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= i2cseq_pkg::PH_IDLE;
      status_r    <= i2cseq_pkg::ST_SUCCESS;
      dir_rd_r    <= 1'b0;
      tgt_r       <= 8'd0;
      regad_r     <= 8'd0;
      total_r     <= 8'd0;
      pos_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      status_r <= status_nxt;
      dir_rd_r <= dir_rd_nxt;
      tgt_r    <= tgt_nxt;
      regad_r  <= regad_nxt;
      total_r  <= total_nxt;
      pos_r    <= pos_nxt;
      if (in_tready) begin
        out_valid_r <= in_acc;
      end
    end
  end

  // A buffer read only starts when the result stage advances, so the RAM
  // output stays put while the result is stalled.
  always_ff @(posedge clk) begin
    if (in_tready) begin
      res_r <= res;
    end
  end

  i2cseq_ram #(
    .WIDTH (8),
    .DEPTH (i2cseq_pkg::BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [7:0] tx_byte;
  assign tx_byte = res_r.tx_from_ram ? ram_rdata : res_r.transmit_byte;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_r.status, res_r.rx_value, res_r.rx_index, res_r.rx_valid,
                       tx_byte, res_r.load_transmit, res_r.send_ack, res_r.enable_receive,
                       res_r.issue_stop, res_r.issue_start, res_r.accepted};

  `ASSERT_AT(a_busy_pending, clk, rst_n,
             (phase_r != i2cseq_pkg::PH_IDLE) |-> (status_r == i2cseq_pkg::ST_PENDING))
  `ASSERT_AT(a_accept_pending, clk, rst_n,
             (out_valid_r && res_r.accepted) |-> (res_r.status == i2cseq_pkg::ST_PENDING))
  `ASSERT_AT(a_read_lands, clk, rst_n,
             ram_re |=> (out_valid_r && res_r.tx_from_ram && res_r.load_transmit))
  `ASSERT_NEVER(a_tx_rx_excl, clk, rst_n,
                out_valid_r && res_r.load_transmit && res_r.rx_valid)

endmodule

[tb/sv/i2c_master_transaction_sequencer_top_tb.sv]
module i2c_master_transaction_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned HOLDOFF_LEN  = 250;
  localparam int unsigned TARGET_ITEMS = 800;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam int STALL_NONE  = 0;
  localparam int STALL_HALF  = 1;
  localparam int STALL_LIGHT = 2;
  localparam int STALL_HEAVY = 3;

  // Request fields, lowest bits last, matching in_tdata.
  typedef struct packed {
    logic [5:0] pad;
    logic [7:0] rx_data;
    logic       collision;
    logic       nack;
    logic [7:0] byte_count;
    logic [7:0] reg_addr;
    logic [7:0] slave_addr;
    logic [7:0] buf_byte;
    logic [7:0] buf_index;
  } seq_req_t;

  // Result fields, lowest bits last, matching out_tdata.
  typedef struct packed {
    logic [6:0]          pad;
    i2cseq_pkg::status_t status;
    logic [7:0]          rx_value;
    logic [7:0]          rx_index;
    logic                rx_valid;
    logic [7:0]          transmit_byte;
    logic                load_transmit;
    logic                send_ack;
    logic                enable_receive;
    logic                issue_stop;
    logic                issue_start;
    logic                accepted;
  } bus_cmd_t;

  class bus_cmd_scoreboard;
    i2cseq_pkg::phase_t  phase;
    i2cseq_pkg::status_t xfer_status;
    bit          dir_read;
    logic [7:0]  target_addr;
    logic [7:0]  register_addr;
    logic [7:0]  total_bytes;
    logic [7:0]  byte_pos;
    logic [7:0]  buffer_mem [i2cseq_pkg::BUF_DEPTH];
    bit          written [i2cseq_pkg::BUF_DEPTH];
    bus_cmd_t    cmd_q [$];
    int unsigned mismatches;

    function new();
      phase = i2cseq_pkg::PH_IDLE;
      xfer_status = i2cseq_pkg::ST_SUCCESS;
      dir_read = 1'b0;
      target_addr = '0;
      register_addr = '0;
      total_bytes = '0;
      byte_pos = '0;
      mismatches = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    // Length of the run of loaded buffer entries starting at position zero, at most 255.
    function int unsigned loaded_prefix();
      int unsigned n;
      n = 0;
      while (n < i2cseq_pkg::BUF_DEPTH - 1 && written[n]) n++;
      return n;
    endfunction

    function int unsigned outstanding();
      return cmd_q.size();
    endfunction

    function void stop_failed(inout bus_cmd_t o);
      o.issue_stop = 1'b1;
      phase = i2cseq_pkg::PH_FAIL_WAIT;
    endfunction

    function void next_write_byte(inout bus_cmd_t o);
      if (byte_pos < total_bytes) begin
        o.load_transmit = 1'b1;
        o.transmit_byte = buffer_mem[byte_pos];
        byte_pos = byte_pos + 8'd1;
        phase = i2cseq_pkg::PH_DATA_ACK;
      end else begin
        o.issue_stop = 1'b1;
        phase = i2cseq_pkg::PH_SUCCESS_WAIT;
      end
    endfunction

    function bus_cmd_t predict(i2cseq_pkg::mode_t m, seq_req_t r);
      bus_cmd_t o;
      o = '0;
      unique case (m)
        i2cseq_pkg::MODE_LOAD: begin
          buffer_mem[r.buf_index] = r.buf_byte;
          written[r.buf_index] = 1'b1;
        end
        i2cseq_pkg::MODE_WRITE, i2cseq_pkg::MODE_READ: begin
          if (xfer_status != i2cseq_pkg::ST_PENDING) begin
            target_addr = r.slave_addr;
            register_addr = r.reg_addr;
            total_bytes = r.byte_count;
            byte_pos = '0;
            dir_read = (m == i2cseq_pkg::MODE_READ);
            xfer_status = i2cseq_pkg::ST_PENDING;
            phase = i2cseq_pkg::PH_SEND_ADDR;
            o.accepted = 1'b1;
            o.issue_start = 1'b1;
          end
        end
        default: begin
          // A collision overrides whatever the event would otherwise mean.
          if (phase != i2cseq_pkg::PH_IDLE && r.collision) begin
            stop_failed(o);
          end else if (phase != i2cseq_pkg::PH_IDLE) begin
            unique case (phase)
              i2cseq_pkg::PH_SEND_ADDR: begin
                o.load_transmit = 1'b1;
                o.transmit_byte = target_addr;
                phase = i2cseq_pkg::PH_ADDR_ACK;
              end
              i2cseq_pkg::PH_ADDR_ACK: begin
                if (r.nack) begin
                  stop_failed(o);
                end else if (dir_read) begin
                  o.load_transmit = 1'b1;
                  o.transmit_byte = register_addr;
                  phase = i2cseq_pkg::PH_RESTART_STOP;
                end else begin
                  next_write_byte(o);
                end
              end
              i2cseq_pkg::PH_DATA_ACK: begin
                if (r.nack) stop_failed(o);
                else next_write_byte(o);
              end
              i2cseq_pkg::PH_RESTART_STOP: begin
                o.issue_stop = 1'b1;
                phase = i2cseq_pkg::PH_RESTART_START;
              end
              i2cseq_pkg::PH_RESTART_START: begin
                o.issue_start = 1'b1;
                phase = i2cseq_pkg::PH_READ_ADDR;
              end
              i2cseq_pkg::PH_READ_ADDR: begin
                o.load_transmit = 1'b1;
                o.transmit_byte = target_addr + 8'd1;
                phase = i2cseq_pkg::PH_FIRST_RX;
              end
              i2cseq_pkg::PH_FIRST_RX: begin
                if (r.nack) begin
                  stop_failed(o);
                end else begin
                  o.enable_receive = 1'b1;
                  phase = i2cseq_pkg::PH_RX_BYTE;
                end
              end
              i2cseq_pkg::PH_RX_BYTE: begin
                buffer_mem[byte_pos] = r.rx_data;
                written[byte_pos] = 1'b1;
                o.rx_valid = 1'b1;
                o.rx_index = byte_pos;
                o.rx_value = r.rx_data;
                byte_pos = byte_pos + 8'd1;
                if (byte_pos < total_bytes) begin
                  o.send_ack = 1'b1;
                  phase = i2cseq_pkg::PH_RX_ENABLE;
                end else begin
                  o.issue_stop = 1'b1;
                  phase = i2cseq_pkg::PH_SUCCESS_WAIT;
                end
              end
              i2cseq_pkg::PH_RX_ENABLE: begin
                o.enable_receive = 1'b1;
                phase = i2cseq_pkg::PH_RX_BYTE;
              end
              i2cseq_pkg::PH_SUCCESS_WAIT: begin
                xfer_status = i2cseq_pkg::ST_SUCCESS;
                phase = i2cseq_pkg::PH_IDLE;
              end
              i2cseq_pkg::PH_FAIL_WAIT: begin
                xfer_status = i2cseq_pkg::ST_FAILED;
                phase = i2cseq_pkg::PH_IDLE;
              end
              default: phase = i2cseq_pkg::PH_IDLE;
            endcase
          end
        end
      endcase
      o.status = xfer_status;
      return o;
    endfunction

    function void note_request(i2cseq_pkg::mode_t m, seq_req_t r);
      cmd_q.push_back(predict(m, r));
    endfunction

    function void check_result(bus_cmd_t act);
      bus_cmd_t exp_c;
      string bad;
      if (cmd_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("ERROR: result %h arrived with no request waiting", act);
        mismatches++;
        return;
      end
      exp_c = cmd_q.pop_front();
      bad = "";
      if (act.accepted !== exp_c.accepted) bad = {bad, " accepted"};
      if (act.issue_start !== exp_c.issue_start) bad = {bad, " issue_start"};
      if (act.issue_stop !== exp_c.issue_stop) bad = {bad, " issue_stop"};
      if (act.enable_receive !== exp_c.enable_receive) bad = {bad, " enable_receive"};
      if (act.send_ack !== exp_c.send_ack) bad = {bad, " send_ack"};
      if (act.load_transmit !== exp_c.load_transmit) bad = {bad, " load_transmit"};
      if (act.transmit_byte !== exp_c.transmit_byte) bad = {bad, " transmit_byte"};
      if (act.rx_valid !== exp_c.rx_valid) bad = {bad, " rx_valid"};
      if (act.rx_index !== exp_c.rx_index) bad = {bad, " rx_index"};
      if (act.rx_value !== exp_c.rx_value) bad = {bad, " rx_value"};
      if (act.status !== exp_c.status) bad = {bad, " status"};
      if (act.pad !== exp_c.pad) bad = {bad, " padding"};
      if (bad != "") begin
        if (mismatches < MAX_REPORTS)
          $display("ERROR: result mismatch in%s: expected %h, got %h", bad, exp_c, act);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  bus_cmd_scoreboard sb;
  int unsigned burst_left;
  int unsigned items_sent;
  int unsigned idle_cycles;
  bit          holdoff_done;

  i2c_master_transaction_sequencer_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_request(i2cseq_pkg::mode_t'(in_tuser), seq_req_t'(in_tdata));
      end
      if (out_tvalid && out_tready) sb.check_result(bus_cmd_t'(out_tdata));
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side: stall patterns of random length, plus one long hold-off
  // that backs the block up and stalls its input.
  initial begin
    int pat;
    int unsigned len;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!holdoff_done && items_sent >= 400) begin
        holdoff_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLDOFF_LEN) @(negedge clk);
      end else begin
        pat = $urandom_range(STALL_NONE, STALL_HEAVY);
        len = $urandom_range(10, 80);
        repeat (len) begin
          unique case (pat)
            STALL_NONE:  out_tready <= 1'b1;
            STALL_HALF:  out_tready <= 1'($urandom_range(0, 1));
            STALL_LIGHT: out_tready <= ($urandom_range(0, 3) != 0);
            default:     out_tready <= ($urandom_range(0, 3) == 0);
          endcase
          @(negedge clk);
        end
      end
    end
  end

  function automatic seq_req_t rand_req();
    seq_req_t r;
    r = seq_req_t'(56'({$urandom, $urandom}));
    r.pad = '0;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(i2cseq_pkg::mode_t m, seq_req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 30);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= r;
    in_tuser  <= m;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic send_load(logic [7:0] idx, logic [7:0] val);
    seq_req_t r;
    r = rand_req();
    r.buf_index = idx;
    r.buf_byte = val;
    send_request(i2cseq_pkg::MODE_LOAD, r);
  endtask

  task automatic send_start(i2cseq_pkg::mode_t m, logic [7:0] saddr, logic [7:0] raddr,
                            logic [7:0] cnt);
    seq_req_t r;
    r = rand_req();
    r.slave_addr = saddr;
    r.reg_addr = raddr;
    r.byte_count = cnt;
    send_request(m, r);
  endtask

  task automatic send_event(logic nk, logic cl, logic [7:0] rxd);
    seq_req_t r;
    r = rand_req();
    r.nack = nk;
    r.collision = cl;
    r.rx_data = rxd;
    send_request(i2cseq_pkg::MODE_EVENT, r);
  endtask

  task automatic run_directed();
    // Events with nothing in progress are ignored, collisions included.
    send_event(1'b1, 1'b1, 8'hFF);
    send_load(8'd0, 8'hFF);
    send_load(8'd255, 8'h00);
    send_load(8'd1, 8'h5A);
    // Empty write, with a second request refused while it is pending.
    send_start(i2cseq_pkg::MODE_WRITE, 8'hFF, 8'h00, 8'd0);
    send_start(i2cseq_pkg::MODE_READ, 8'h00, 8'hFF, 8'd255);
    send_event(1'b1, 1'b0, 8'h00);
    send_event(1'b0, 1'b0, 8'h00);
    send_event(1'b0, 1'b0, 8'h00);
    // Empty read still takes one byte; nack is ignored around the restart.
    send_start(i2cseq_pkg::MODE_READ, 8'h00, 8'hFF, 8'd0);
    send_event(1'b0, 1'b0, 8'h00);
    send_event(1'b0, 1'b0, 8'h00);
    send_event(1'b1, 1'b0, 8'h00);
    send_event(1'b1, 1'b0, 8'h00);
    send_event(1'b1, 1'b0, 8'h00);
    send_event(1'b0, 1'b0, 8'h00);
    send_event(1'b0, 1'b0, 8'hFF);
    send_event(1'b0, 1'b0, 8'h00);
    // Collision in the middle of a write.
    send_start(i2cseq_pkg::MODE_WRITE, 8'h7E, 8'h81, 8'd2);
    send_event(1'b0, 1'b0, 8'h00);
    send_event(1'b0, 1'b0, 8'h00);
    send_event(1'b1, 1'b1, 8'h00);
    send_event(1'b0, 1'b0, 8'h00);
    // Address not acknowledged.
    send_start(i2cseq_pkg::MODE_WRITE, 8'hA0, 8'h00, 8'd1);
    send_event(1'b0, 1'b0, 8'h00);
    send_event(1'b1, 1'b0, 8'h00);
    send_event(1'b0, 1'b0, 8'h00);
  endtask

  task automatic run_random();
    int unsigned pick;
    int unsigned cap;
    logic [7:0]  cnt;
    bit          noisy;
    bit          big_read_done;
    noisy = 1'b0;
    big_read_done = 1'b0;
    while (items_sent < TARGET_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (sb.phase == i2cseq_pkg::PH_IDLE) begin
        if (pick < 25) begin
          send_load(8'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 15)
                                                  : $urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
          items_sent++;
        end else if (pick < 30) begin
          // Ignored by the block, so not counted.
          send_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)));
        end else begin
          noisy = ($urandom_range(0, 3) == 0);
          if (!big_read_done && items_sent > 200) begin
            big_read_done = 1'b1;
            noisy = 1'b0;
            send_start(i2cseq_pkg::MODE_READ, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'd255);
          end else if (pick < 65) begin
            cap = sb.loaded_prefix();
            cnt = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, cap)
                                                 : $urandom_range(0, (cap < 6) ? cap : 6));
            send_start(i2cseq_pkg::MODE_WRITE, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), cnt);
          end else begin
            cnt = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                 : $urandom_range(0, 6));
            send_start(i2cseq_pkg::MODE_READ, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), cnt);
          end
          items_sent++;
        end
      end else begin
        if (pick < 6) begin
          send_load(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end else if (pick < 10) begin
          // Refused: a transfer is still pending.
          send_start(($urandom_range(0, 1) != 0) ? i2cseq_pkg::MODE_READ
                                                 : i2cseq_pkg::MODE_WRITE,
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        end else begin
          send_event(noisy && ($urandom_range(0, 5) == 0),
                     noisy && ($urandom_range(0, 19) == 0),
                     8'($urandom_range(0, 255)));
        end
        items_sent++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = i2cseq_pkg::MODE_LOAD;
    burst_left = 0;
    items_sent = 0;
    idle_cycles = 0;
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    run_random();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
